### sv/shash_pkg.sv
// ----------------------------------------------------------------------------
// shash_pkg: shared types, constants and microprogram of the string hash
// Holds the control word layout, the datapath register map and the read-only
// program that the sequencer steps through for byte beats and end beats.
// ----------------------------------------------------------------------------
package shash_pkg;

	// Hash constants
	localparam logic [31:0] SEED_INIT  = 32'd1111111111;
	localparam logic [31:0] MIX_ADD    = 32'd111111111;
	localparam logic [3:0]  SEED_BYTES = 4'd7;
	localparam logic [3:0]  POS_SAT    = 4'd8;

	// Register file map: work words, seed words, one scratch word
	localparam int          NREG = 17;
	localparam logic [4:0]  R_W0 = 5'd0;
	localparam logic [4:0]  R_W1 = 5'd1;
	localparam logic [4:0]  R_W6 = 5'd6;
	localparam logic [4:0]  R_W7 = 5'd7;
	localparam logic [4:0]  R_S0 = 5'd8;
	localparam logic [4:0]  R_S1 = 5'd9;
	localparam logic [4:0]  R_S2 = 5'd10;
	localparam logic [4:0]  R_S3 = 5'd11;
	localparam logic [4:0]  R_S4 = 5'd12;
	localparam logic [4:0]  R_S5 = 5'd13;
	localparam logic [4:0]  R_S6 = 5'd14;
	localparam logic [4:0]  R_S7 = 5'd15;
	localparam logic [4:0]  R_T0 = 5'd16;

	// ALU operations
	localparam logic [3:0] OP_HOLD = 4'd0;
	localparam logic [3:0] OP_LD   = 4'd1;
	localparam logic [3:0] OP_ADD  = 4'd2;
	localparam logic [3:0] OP_XOR  = 4'd3;
	localparam logic [3:0] OP_SHA  = 4'd4; // acc + ((acc + opnd) << 9)
	localparam logic [3:0] OP_SHL  = 4'd5;
	localparam logic [3:0] OP_SHR  = 4'd6;
	localparam logic [3:0] OP_XA   = 4'd7; // xor on even index, add on odd
	localparam logic [3:0] OP_AX   = 4'd8; // add on even index, xor on odd

	// Operand sources
	localparam logic [1:0] OS_RF   = 2'd0;
	localparam logic [1:0] OS_INIT = 2'd1;
	localparam logic [1:0] OS_MIX  = 2'd2;
	localparam logic [1:0] OS_BYTE = 2'd3;

	// Address modes
	localparam logic [1:0] AM_ABS = 2'd0; // fixed register
	localparam logic [1:0] AM_IDX = 2'd1; // bank + (offset + k) mod 8
	localparam logic [1:0] AM_IDN = 2'd2; // bank + (offset - k) mod 8
	localparam logic [1:0] AM_DAT = 2'd3; // work word picked by acc[2:0]

	// Jump conditions
	localparam logic [2:0] C_NONE   = 3'd0;
	localparam logic [2:0] C_ALWAYS = 3'd1;
	localparam logic [2:0] C_K_LT   = 3'd2;
	localparam logic [2:0] C_K_GE   = 3'd3;
	localparam logic [2:0] C_BP_GE  = 3'd4;

	// Index register operations
	localparam logic [2:0] K_HOLD = 3'd0;
	localparam logic [2:0] K_INC  = 3'd1;
	localparam logic [2:0] K_CLR  = 3'd2;
	localparam logic [2:0] K_BP   = 3'd3;
	localparam logic [2:0] K_STEP = 3'd4; // increment when jumping, else clear

	// Program labels
	localparam logic [5:0] L_BYTE   = 6'd0;
	localparam logic [5:0] L_B_WORK = 6'd3;
	localparam logic [5:0] L_FIN    = 6'd7;
	localparam logic [5:0] L_L1_END = 6'd11;
	localparam logic [5:0] L_L2_TOP = 6'd12;
	localparam logic [5:0] L_L2_END = 6'd17;
	localparam logic [5:0] L_ST     = 6'd18;
	localparam logic [5:0] L_MIX1   = 6'd20;
	localparam logic [5:0] L_MIX2   = 6'd24;
	localparam logic [5:0] L_DIX    = 6'd27;
	localparam logic [5:0] L_EMIT   = 6'd50;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] osel;
		logic [1:0] amode;
		logic [4:0] addr;
		logic       we;
		logic [1:0] dmode;
		logic [4:0] daddr;
		logic       dual;   // also write the same slot of the other bank
		logic       shk;    // shift by 10 - k instead of shamt
		logic [4:0] shamt;
		logic [2:0] cond;
		logic [3:0] lim;
		logic [5:0] target;
		logic [2:0] kop;
		logic       emit;
		logic       bdone;
		logic       reinit;
		logic       fin;
	} ctrl_t;

	// Microprogram
	function automatic ctrl_t rom(input logic [5:0] pc);
		ctrl_t c;
		c = '0;
		case (pc)
			// byte beat: seed step while fewer than seven bytes taken
			6'd0: begin
				c.op = OP_LD; c.osel = OS_BYTE;
				c.cond = C_BP_GE; c.lim = SEED_BYTES; c.target = L_B_WORK;
			end
			6'd1: begin
				c.op = OP_ADD; c.amode = AM_IDX; c.addr = R_S0;
			end
			6'd2: begin
				c.op = OP_SHA; c.osel = OS_MIX;
				c.we = 1'b1; c.dmode = AM_IDX; c.daddr = R_S1; c.dual = 1'b1;
			end
			// byte beat: working word update
			6'd3: begin
				c.op = OP_LD; c.amode = AM_IDX; c.addr = R_W0;
			end
			6'd4: begin
				c.op = OP_ADD; c.osel = OS_BYTE;
			end
			6'd5: begin
				c.op = OP_ADD; c.amode = AM_IDX; c.addr = R_W1;
			end
			6'd6: begin
				c.op = OP_SHA; c.osel = OS_INIT;
				c.we = 1'b1; c.dmode = AM_IDX; c.daddr = R_W0;
				c.bdone = 1'b1; c.fin = 1'b1;
			end
			// end beat: pad missing seeds
			6'd7: begin
				c.cond = C_K_GE; c.lim = SEED_BYTES; c.target = L_L1_END;
			end
			6'd8: begin
				c.op = OP_LD; c.amode = AM_IDX; c.addr = R_S0;
			end
			6'd9: begin
				c.op = OP_ADD; c.osel = OS_INIT;
			end
			6'd10: begin
				c.op = OP_SHA; c.osel = OS_MIX;
				c.we = 1'b1; c.dmode = AM_IDX; c.daddr = R_S1; c.dual = 1'b1;
				c.kop = K_INC; c.cond = C_ALWAYS; c.target = L_FIN;
			end
			// pad missing working words
			6'd11: begin
				c.kop = K_BP;
			end
			6'd12: begin
				c.cond = C_K_GE; c.lim = SEED_BYTES; c.target = L_L2_END;
			end
			6'd13: begin
				c.op = OP_LD; c.amode = AM_IDX; c.addr = R_W0;
			end
			6'd14: begin
				c.op = OP_ADD; c.amode = AM_IDX; c.addr = R_W1;
			end
			6'd15: begin
				c.op = OP_ADD; c.osel = OS_INIT;
			end
			6'd16: begin
				c.op = OP_SHA; c.osel = OS_MIX;
				c.we = 1'b1; c.dmode = AM_IDX; c.daddr = R_W0;
				c.kop = K_INC; c.cond = C_ALWAYS; c.target = L_L2_TOP;
			end
			6'd17: begin
				c.kop = K_CLR;
			end
			// st[k] = seed[k] + work[k], kept in the seed bank
			6'd18: begin
				c.op = OP_LD; c.amode = AM_IDX; c.addr = R_S0;
			end
			6'd19: begin
				c.op = OP_ADD; c.amode = AM_IDX; c.addr = R_W0;
				c.we = 1'b1; c.dmode = AM_IDX; c.daddr = R_S0;
				c.kop = K_STEP; c.cond = C_K_LT; c.lim = 4'd7; c.target = L_ST;
			end
			// first mix round over h[k-2], h[k-1]
			6'd20: begin
				c.op = OP_LD; c.amode = AM_IDX; c.addr = R_W6;
			end
			6'd21: begin
				c.op = OP_XA; c.amode = AM_IDX; c.addr = R_W7;
			end
			6'd22: begin
				c.op = OP_SHL; c.shk = 1'b1;
			end
			6'd23: begin
				c.op = OP_AX; c.amode = AM_IDX; c.addr = R_W0;
				c.we = 1'b1; c.dmode = AM_IDX; c.daddr = R_W0;
				c.kop = K_STEP; c.cond = C_K_LT; c.lim = 4'd7; c.target = L_MIX1;
			end
			// second mix round with st
			6'd24: begin
				c.op = OP_LD; c.amode = AM_IDX; c.addr = R_W7;
			end
			6'd25: begin
				c.op = OP_XOR; c.amode = AM_IDX; c.addr = R_S0;
			end
			6'd26: begin
				c.op = OP_AX; c.amode = AM_IDX; c.addr = R_W0;
				c.we = 1'b1; c.dmode = AM_IDX; c.daddr = R_W0;
				c.kop = K_STEP; c.cond = C_K_LT; c.lim = 4'd7; c.target = L_MIX2;
			end
			// data-indexed rounds, word j = 6 - k
			6'd27: begin
				c.op = OP_LD; c.amode = AM_IDN; c.addr = R_W6;
			end
			6'd28: begin
				c.op = OP_XOR; c.amode = AM_IDX; c.addr = R_S0;
			end
			6'd29: begin
				c.op = OP_LD; c.amode = AM_DAT;
				c.we = 1'b1; c.daddr = R_T0;
			end
			6'd30: begin
				c.op = OP_LD; c.amode = AM_IDN; c.addr = R_W6;
			end
			6'd31: begin
				c.op = OP_XOR; c.amode = AM_IDX; c.addr = R_S1;
			end
			6'd32: begin
				c.op = OP_ADD; c.addr = R_T0;
			end
			6'd33: begin
				c.op = OP_ADD; c.amode = AM_IDX; c.addr = R_S2;
			end
			6'd34: begin
				c.op = OP_SHR; c.shk = 1'b1;
				c.we = 1'b1; c.daddr = R_T0;
			end
			6'd35: begin
				c.op = OP_LD; c.amode = AM_IDN; c.addr = R_W7;
			end
			6'd36: begin
				c.op = OP_XOR; c.amode = AM_IDX; c.addr = R_S3;
			end
			6'd37: begin
				c.op = OP_ADD; c.addr = R_T0;
			end
			6'd38: begin
				c.op = OP_ADD; c.amode = AM_IDN; c.addr = R_W6;
				c.we = 1'b1; c.dmode = AM_IDN; c.daddr = R_W6;
				c.kop = K_STEP; c.cond = C_K_LT; c.lim = 4'd6; c.target = L_DIX;
			end
			// final fold into h[7]
			6'd39: begin c.op = OP_LD;  c.addr = R_S1; end
			6'd40: begin c.op = OP_XOR; c.addr = R_S2; end
			6'd41: begin c.op = OP_XOR; c.addr = R_S3; end
			6'd42: begin
				c.op = OP_SHL; c.shamt = 5'd16;
				c.we = 1'b1; c.daddr = R_T0;
			end
			6'd43: begin c.op = OP_LD;  c.addr = R_S4; end
			6'd44: begin c.op = OP_XOR; c.addr = R_S5; end
			6'd45: begin c.op = OP_XOR; c.addr = R_S6; end
			6'd46: begin c.op = OP_SHR; c.shamt = 5'd16; end
			6'd47: begin c.op = OP_ADD; c.addr = R_T0; end
			6'd48: begin c.op = OP_ADD; c.addr = R_S7; end
			6'd49: begin
				c.op = OP_ADD; c.addr = R_W7;
				c.we = 1'b1; c.daddr = R_W7;
			end
			// emit the eight words
			6'd50: begin
				c.amode = AM_IDX; c.addr = R_W0; c.emit = 1'b1;
				c.kop = K_STEP; c.cond = C_K_LT; c.lim = 4'd7; c.target = L_EMIT;
			end
			6'd51: begin
				c.reinit = 1'b1; c.fin = 1'b1;
			end
			default: begin
				c.fin = 1'b1;
			end
		endcase
		return c;
	endfunction

endpackage

### sv/string_hash_256.sv
// A byte beat runs the seed step and then the working-word update (only the
// update once seven bytes are in); an end beat's length depends on message length and on output stalls.
// Throughput: one beat at a time; the next beat is taken the cycle after the
// program ends, set by the one-operation-per-step accumulator datapath.
// Results leave through an output register, one word per emit step.
// Reset: arst_n clears the sequencer and restores the start-of-message state.
// ----------------------------------------------------------------------------
// string_hash_256: microcoded byte-stream hash with eight 32-bit result words
// A step counter walks a read-only program; each control word drives the
// accumulator datapath, the index register and the result register.
// ----------------------------------------------------------------------------
module string_hash_256 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] hash_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast
);

	shash_pkg::ctrl_t ctrl;
	logic        busy_q;
	logic [5:0]  pc_q;
	logic [3:0]  k_q;
	logic [3:0]  bp_q;
	logic [2:0]  wrap_q;
	logic        m_valid_q;
	logic [31:0] m_data_q;
	logic [2:0]  m_index_q;
	logic        m_last_q;
	logic        s_fire;
	logic        is_end;
	logic        stall;
	logic        adv;
	logic        taken;
	logic [31:0] opnd;

	assign ctrl          = shash_pkg::rom(pc_q);
	assign s_axis_tready = !busy_q;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign is_end        = s_axis_tuser || (s_axis_tdata == 8'd0);
	assign stall         = ctrl.emit && m_valid_q && !m_axis_tready;
	assign adv           = busy_q && !stall;

	// Evaluate the jump condition
	always_comb begin
		case (ctrl.cond)
			shash_pkg::C_ALWAYS: taken = 1'b1;
			shash_pkg::C_K_LT:   taken = (k_q < ctrl.lim);
			shash_pkg::C_K_GE:   taken = (k_q >= ctrl.lim);
			shash_pkg::C_BP_GE:  taken = (bp_q >= ctrl.lim);
			default:             taken = 1'b0;
		endcase
	end

	// Sequencer: start on an accepted beat, step, jump, stop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= shash_pkg::L_BYTE;
			k_q    <= 4'd0;
			bp_q   <= 4'd0;
			wrap_q <= 3'd0;
		end else if (s_fire) begin
			busy_q <= 1'b1;
			pc_q   <= is_end ? shash_pkg::L_FIN : shash_pkg::L_BYTE;
			k_q    <= is_end ? bp_q : {1'b0, wrap_q};
		end else if (adv) begin
			pc_q <= taken ? ctrl.target : 6'(pc_q + 6'd1);
			if (ctrl.fin) begin
				busy_q <= 1'b0;
			end
			case (ctrl.kop)
				shash_pkg::K_INC:  k_q <= 4'(k_q + 4'd1);
				shash_pkg::K_CLR:  k_q <= 4'd0;
				shash_pkg::K_BP:   k_q <= bp_q;
				shash_pkg::K_STEP: k_q <= taken ? 4'(k_q + 4'd1) : 4'd0;
				default:           k_q <= k_q;
			endcase
			// advance byte count and wrap position, or restart the message
			if (ctrl.reinit) begin
				bp_q   <= 4'd0;
				wrap_q <= 3'd0;
			end else if (ctrl.bdone) begin
				wrap_q <= 3'(wrap_q + 3'd1);
				if (bp_q != shash_pkg::POS_SAT) begin
					bp_q <= 4'(bp_q + 4'd1);
				end
			end
		end
	end

	// Result register: load on an emit step, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && ctrl.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctrl.emit) begin
			m_data_q  <= opnd;
			m_index_q <= k_q[2:0];
			m_last_q  <= (k_q[2:0] == 3'd7);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_index_q;
	assign m_axis_tlast  = m_last_q;

	shash_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.adv     (adv),
		.kidx    (k_q[2:0]),
		.byte_ld (s_fire),
		.byte_in (s_axis_tdata),
		.opnd    (opnd)
	);

endmodule

### sv/shash_datapath.sv
// ----------------------------------------------------------------------------
// shash_datapath: register file and accumulator ALU of the string hash
// Executes one control word per step: reads one register or constant, combines
// it with the accumulator and optionally writes the result back.
// ----------------------------------------------------------------------------
module shash_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  shash_pkg::ctrl_t    ctrl,
	input  logic                adv,
	input  logic [2:0]          kidx,
	input  logic                byte_ld,
	input  logic [7:0]          byte_in,
	output logic [31:0]         opnd
);

	logic [31:0] rf_q [shash_pkg::NREG];
	logic [31:0] acc_q;
	logic [31:0] b_q;
	logic [31:0] res;
	logic [31:0] sum;
	logic [4:0]  raddr;
	logic [4:0]  waddr;
	logic [4:0]  shamt;

	function automatic logic [4:0] addr_calc(input logic [1:0] mode, input logic [4:0] base,
			input logic [2:0] k, input logic [2:0] acc_lo);
		logic [4:0] a;
		case (mode)
			shash_pkg::AM_IDX: a = {base[4:3], 3'(base[2:0] + k)};
			shash_pkg::AM_IDN: a = {base[4:3], 3'(base[2:0] - k)};
			shash_pkg::AM_DAT: a = {2'b00, acc_lo};
			default:           a = base;
		endcase
		return a;
	endfunction

	// Resolve addresses and operand
	always_comb begin
		raddr = addr_calc(ctrl.amode, ctrl.addr, kidx, acc_q[2:0]);
		waddr = addr_calc(ctrl.dmode, ctrl.daddr, kidx, acc_q[2:0]);
		case (ctrl.osel)
			shash_pkg::OS_INIT: opnd = shash_pkg::SEED_INIT;
			shash_pkg::OS_MIX:  opnd = shash_pkg::MIX_ADD;
			shash_pkg::OS_BYTE: opnd = b_q;
			default:            opnd = rf_q[raddr];
		endcase
		shamt = ctrl.shk ? 5'(5'd10 - {2'b00, kidx}) : ctrl.shamt;
	end

	// ALU
	always_comb begin
		sum = acc_q + opnd;
		case (ctrl.op)
			shash_pkg::OP_LD:  res = opnd;
			shash_pkg::OP_ADD: res = sum;
			shash_pkg::OP_XOR: res = acc_q ^ opnd;
			shash_pkg::OP_SHA: res = acc_q + (sum << 9);
			shash_pkg::OP_SHL: res = acc_q << shamt;
			shash_pkg::OP_SHR: res = acc_q >> shamt;
			shash_pkg::OP_XA:  res = kidx[0] ? sum : (acc_q ^ opnd);
			shash_pkg::OP_AX:  res = kidx[0] ? (acc_q ^ opnd) : sum;
			default:           res = acc_q;
		endcase
	end

	// Accumulator advances with the sequencer
	always_ff @(posedge clk) begin
		if (adv) begin
			acc_q <= res;
		end
	end

	// Latch the sign-extended message byte
	always_ff @(posedge clk) begin
		if (byte_ld) begin
			b_q <= {{24{byte_in[7]}}, byte_in};
		end
	end

	// Register file: write back, reinit to the start-of-message values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < shash_pkg::NREG; i++) begin
				rf_q[i] <= (5'(i) == shash_pkg::R_W0 || 5'(i) == shash_pkg::R_S0) ?
					shash_pkg::SEED_INIT : 32'd0;
			end
		end else if (adv) begin
			if (ctrl.reinit) begin
				for (int i = 0; i < shash_pkg::NREG; i++) begin
					rf_q[i] <= (5'(i) == shash_pkg::R_W0 || 5'(i) == shash_pkg::R_S0) ?
						shash_pkg::SEED_INIT : 32'd0;
				end
			end else if (ctrl.we) begin
				rf_q[waddr] <= res;
				if (ctrl.dual) begin
					rf_q[{waddr[4], ~waddr[3], waddr[2:0]}] <= res;
				end
			end
		end
	end

endmodule
